### hw/rtl/cepf_pkg.sv
// Shared types and constants for the column extreme pixel finder.
// Used by column_extreme_pixel_finder_unit; no dependencies.
`timescale 1ns / 1ps

package cepf_pkg;

  // Field widths of the stream payloads
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned FRAME_W    = 11;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  // Default sizes
  localparam int unsigned MAX_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF    = 1024;

  // Configuration port
  localparam int unsigned            CFG_ADDR_W      = 2;
  localparam int unsigned            CFG_DATA_W      = 32;
  localparam logic [CFG_ADDR_W-1:0]  REG_FRAME_ROWS  = 2'd0;
  localparam logic [FRAME_W-1:0]     FRAME_ROWS_RST  = 11'd480;

  // One column entry as stored in the RAM
  typedef struct packed {
    logic             seen;
    logic [ROW_W-1:0] ceil_row;
    logic [ROW_W-1:0] floor_row;
  } col_entry_t;

  localparam int unsigned ENTRY_W = $bits(col_entry_t);

endpackage

### hw/rtl/cepf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read data holds when no read is requested.
`timescale 1ns / 1ps

module cepf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port (read-before-write on the same address)
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/column_extreme_pixel_finder_unit.sv
// Column extreme pixel finder, top level. Depends on cepf_pkg and cepf_ram.
// Tracks topmost and bottommost nonzero pixel rows per column over a raster frame.
`timescale 1ns / 1ps

// Pixels arrive in raster order, one request per clock with its row and
// column. Each column keeps a ceiling row, a floor row and a found flag in one
// RAM of MAX_COLUMNS entries; a row-0 pixel restarts the entry, and a pixel of
// row frame_rows-1 produces one result for its column. The block takes one
// pixel every clock: the read-modify-write runs in two stages (RAM read, then
// update and write-back), and a forwarding register covers a pixel that hits
// the column written in the cycle before. Results leave through the output
// register. Input is held off only while a result waits in the output register
// and the pixel in the update stage also produces one. The RAM is not cleared
// at reset: each column must see a row-0 pixel before its last-row pixel.
module column_extreme_pixel_finder_unit #(
  parameter int unsigned MAX_COLUMNS = cepf_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = cepf_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Pixel stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] pixel_value, [17:8] pixel_row, [27:18] pixel_column, [31:28] zero
  input  logic [cepf_pkg::IN_DATA_W-1:0]      in_tdata,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [9:0] result_column, [19:10] ceiling_row, [29:20] floor_row, [31:30] zero
  output logic [cepf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] column_found
  output logic                                out_tuser,
  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cepf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [cepf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [cepf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import cepf_pkg::*;

  localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // Configuration register
  logic [FRAME_W-1:0] frame_rows_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_FRAME_ROWS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= FRAME_ROWS_RST;
    end else if (cfg_wr) begin
      frame_rows_r <= pwdata[FRAME_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_FRAME_ROWS) begin
      prdata = CFG_DATA_W'(frame_rows_r);
    end
  end

  // Input unpacking
  logic [PIX_W-1:0] in_pix;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_accept;
  logic             in_range;

  assign in_pix    = in_tdata[PIX_W-1:0];
  assign in_row    = in_tdata[PIX_W +: ROW_W];
  assign in_col    = in_tdata[PIX_W+ROW_W +: COL_W];
  assign in_accept = in_tvalid && in_tready;
  assign in_range  = (32'(in_col) < 32'(MAX_COLUMNS)) && (32'(in_row) < 32'(MAX_ROWS));

  // Update stage registers
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_set_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;

  // Forwarding register: last entry written to the RAM
  logic             fwd_valid_r;
  logic [AW-1:0]    fwd_addr_r;
  col_entry_t       fwd_data_r;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_ceil_r;
  logic [ROW_W-1:0] out_floor_r;
  logic             out_found_r;

  // RAM interface
  logic [AW-1:0]    s1_addr;
  logic             mem_we;
  col_entry_t       rd_entry;
  logic [ENTRY_W-1:0] rd_raw;
  col_entry_t       cur_entry;
  col_entry_t       new_entry;

  cepf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_COLUMNS),
    .AW    (AW)
  ) u_col_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr),
    .wdata (ENTRY_W'(new_entry)),
    .re    (in_accept),
    .raddr (AW'(in_col)),
    .rdata (rd_raw)
  );

  assign rd_entry = col_entry_t'(rd_raw);
  assign s1_addr  = AW'(s1_col_r);

  // Entry update and stage advance
  logic [FRAME_W-1:0] last_row;
  logic               s1_emit;
  logic               s1_adv;

  always_comb begin
    cur_entry = (fwd_valid_r && (fwd_addr_r == s1_addr)) ? fwd_data_r : rd_entry;
    new_entry = cur_entry;
    if (s1_row_r == '0) begin
      new_entry.seen      = s1_set_r;
      new_entry.ceil_row  = '0;
      new_entry.floor_row = '0;
    end else if (s1_set_r) begin
      if (!cur_entry.seen) begin
        new_entry.ceil_row = s1_row_r;
      end
      new_entry.floor_row = s1_row_r;
      new_entry.seen      = 1'b1;
    end
  end

  assign last_row  = frame_rows_r - FRAME_W'(1);
  assign s1_emit   = s1_valid_r && (FRAME_W'(s1_row_r) == last_row);
  assign s1_adv    = !(s1_emit && out_valid_r && !out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign mem_we    = s1_valid_r && s1_adv;

  // Next-state for stage and output valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_accept && in_range;
    end
    out_valid_nxt = out_valid_r;
    if (s1_emit && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_set_r <= (in_pix != '0);
      s1_row_r <= in_row;
      s1_col_r <= in_col;
    end
    if (mem_we) begin
      fwd_addr_r <= s1_addr;
      fwd_data_r <= new_entry;
    end
    if (s1_emit && s1_adv) begin
      out_col_r   <= s1_col_r;
      out_found_r <= new_entry.seen;
      out_ceil_r  <= new_entry.seen ? new_entry.ceil_row  : '0;
      out_floor_r <= new_entry.seen ? new_entry.floor_row : '0;
    end
  end

  // Output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_DATA_W'({out_floor_r, out_ceil_r, out_col_r});

  // Checks
  a_we_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> s1_valid_r)
    else $error("RAM write without a pixel in the update stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_emit && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (fwd_valid_r && fwd_addr_r == $past(s1_addr)))
    else $error("forwarding register missed the last RAM write");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_ceil_r == '0 && out_floor_r == '0))
    else $error("rows nonzero on a column without set pixels");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_emit && s1_adv) |=> out_valid_r)
    else $error("last-row pixel did not produce a result");

endmodule
